// ===== rtl/periodic_oneshot_timer_bank_unit_macros.svh =====
// Assertion macros shared by the timer bank RTL.
// Include once by bare file name; no other dependencies.
`ifndef PERIODIC_ONESHOT_TIMER_BANK_UNIT_MACROS_SVH
`define PERIODIC_ONESHOT_TIMER_BANK_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset
`define POTB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent
`define POTB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/potb_pkg.sv =====
// Package for the periodic/one-shot timer bank: sizes, codes and field widths.
// No dependencies.
`default_nettype none
package potb_pkg;
  localparam int NUM_TIMERS    = 16;
  localparam int TW            = 4;   // timer slot index width
  localparam int ACW           = 5;   // active count width
  localparam int PENDING_DEPTH = 8;
  localparam int PW            = 3;   // pending index width
  localparam int PCW           = 4;   // pending count width
  localparam int RESULT_LIMIT  = 8;
  localparam int PERW          = 31;
  localparam int TAGW          = 16;
  localparam int DROPW         = 5;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_ADD_P  = 3'd1,
    ACT_ADD_O  = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_DRAIN  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_PER  = 3'd2,
    ST_NO_TIMER = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;
endpackage
`default_nettype wire

// ===== rtl/periodic_oneshot_timer_bank_unit.sv =====
// Top level of the periodic/one-shot timer bank with its sequencer.
// Depends on potb_pkg and periodic_oneshot_timer_bank_unit_macros.svh.
`default_nettype none
`include "periodic_oneshot_timer_bank_unit_macros.svh"

// A bank of 16 countdown timers with an 8-entry pending expiration queue.
// One transaction is taken at a time; in_tready is low while it is worked on.
// Add, bad-period, table-full, empty-drain and unknown actions give their result
// through the S_RESP state, and in_tready returns once that result is loaded.
// A tick walks the active list through one shared decrement-and-compare unit,
// one timer per cycle: its result follows through S_RESP once the scan ends.
// A remove scans the active list the same way to close the gap. A drain sends up
// to 8 results, one per cycle while out_tready is high.
// No clearing pass follows reset.
module periodic_oneshot_timer_bank_unit
  import potb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,   // action[2:0] period[33:3] handle[37:34] tag[53:38]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // status[2:0] slot[6:3] expired_tag[22:7] dropped[27:23]
  output logic             out_tlast
);

  typedef enum logic [2:0] {S_IDLE, S_TICK, S_REM, S_DRAIN, S_RESP} state_t;

  state_t state_r;

  // timer table
  logic [PERW-1:0] per_r  [NUM_TIMERS];
  logic [PERW-1:0] rem_r  [NUM_TIMERS];
  logic            rep_r  [NUM_TIMERS];
  logic [TAGW-1:0] tag_r  [NUM_TIMERS];
  logic [TW-1:0]   order_r[NUM_TIMERS];
  logic [NUM_TIMERS-1:0] busy_r;
  logic [ACW-1:0]  act_cnt_r;

  // pending queue
  logic [TAGW-1:0] ptag_r [PENDING_DEPTH];
  logic [TW-1:0]   pslot_r[PENDING_DEPTH];
  logic [PCW-1:0]  pend_cnt_r;
  logic [PW-1:0]   pend_head_r;

  // sequencer
  logic [ACW-1:0]   idx_r, wr_r;
  logic [DROPW-1:0] drop_r;
  logic             found_r;
  logic [TW-1:0]    hnd_r;
  logic [PCW-1:0]   k_r;
  status_t          rs_status_r;
  logic [TW-1:0]    rs_slot_r;

  // output register
  logic             out_valid_r;
  logic [31:0]      out_data_r;
  logic             out_last_r;

  // input fields
  action_t         in_action;
  logic [PERW-1:0] in_period;
  logic [TW-1:0]   in_handle;
  logic [TAGW-1:0] in_tag;
  assign in_action = action_t'(in_tdata[2:0]);
  assign in_period = in_tdata[33:3];
  assign in_handle = in_tdata[37:34];
  assign in_tag    = in_tdata[53:38];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // output register loads a new result this cycle
  logic out_load;
  assign out_load = out_free && ((state_r == S_DRAIN) || (state_r == S_RESP));

  // lowest free slot
  logic [TW-1:0] free_slot;
  always_comb begin
    free_slot = '0;
    for (int s = NUM_TIMERS - 1; s >= 0; s--) begin
      if (!busy_r[s]) free_slot = TW'(s);
    end
  end

  // shared decrement-and-compare unit, on the timer at the scan position
  logic [TW-1:0]   cur_slot;
  logic [PERW-1:0] dec_val;
  logic            dec_zero;
  logic [PW-1:0]   tail;
  assign cur_slot = order_r[idx_r[TW-1:0]];
  assign dec_val  = rem_r[cur_slot] - PERW'(1);
  assign dec_zero = (dec_val == '0);
  assign tail     = pend_head_r + pend_cnt_r[PW-1:0];

  logic scan_more;
  assign scan_more = (idx_r < act_cnt_r);

  // sequencer, tables and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      act_cnt_r   <= '0;
      pend_cnt_r  <= '0;
      pend_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            idx_r       <= '0;
            wr_r        <= '0;
            drop_r      <= '0;
            found_r     <= 1'b0;
            k_r         <= '0;
            hnd_r       <= in_handle;
            unique case (in_action)
              ACT_TICK: begin
                rs_status_r <= ST_OK;
                rs_slot_r   <= '0;
                state_r     <= S_TICK;
              end
              ACT_ADD_P, ACT_ADD_O: begin
                state_r <= S_RESP;
                if (in_period == '0) begin
                  rs_status_r <= ST_BAD_PER;
                  rs_slot_r   <= '0;
                end else if (act_cnt_r >= ACW'(NUM_TIMERS)) begin
                  rs_status_r <= ST_FULL;
                  rs_slot_r   <= '0;
                end else begin
                  per_r[free_slot]              <= in_period;
                  rem_r[free_slot]              <= in_period;
                  rep_r[free_slot]              <= (in_action == ACT_ADD_P);
                  tag_r[free_slot]              <= in_tag;
                  order_r[act_cnt_r[TW-1:0]]    <= free_slot;
                  act_cnt_r                     <= act_cnt_r + ACW'(1);
                  busy_r[free_slot]             <= 1'b1;
                  rs_status_r                   <= ST_OK;
                  rs_slot_r                     <= free_slot;
                end
              end
              ACT_REMOVE: begin
                rs_slot_r <= '0;
                if (busy_r[in_handle]) begin
                  rs_status_r <= ST_OK;
                  state_r     <= S_REM;
                end else begin
                  rs_status_r <= ST_NO_TIMER;
                  state_r     <= S_RESP;
                end
              end
              ACT_DRAIN: begin
                rs_slot_r <= '0;
                if (pend_cnt_r == '0) begin
                  rs_status_r <= ST_EMPTY;
                  state_r     <= S_RESP;
                end else begin
                  rs_status_r <= ST_OK;
                  state_r     <= S_DRAIN;
                end
              end
              default: begin
                rs_status_r <= ST_OK;
                rs_slot_r   <= '0;
                state_r     <= S_RESP;
              end
            endcase
          end
        end
        S_TICK: begin
          if (scan_more) begin
            if (dec_zero) begin
              if (pend_cnt_r < PCW'(PENDING_DEPTH)) begin
                ptag_r[tail]  <= tag_r[cur_slot];
                pslot_r[tail] <= cur_slot;
                pend_cnt_r    <= pend_cnt_r + PCW'(1);
              end else if (drop_r != '1) begin
                drop_r <= drop_r + DROPW'(1);
              end
              if (rep_r[cur_slot]) begin
                rem_r[cur_slot]          <= per_r[cur_slot];
                order_r[wr_r[TW-1:0]]    <= cur_slot;
                wr_r                     <= wr_r + ACW'(1);
              end else begin
                rem_r[cur_slot]  <= '0;
                busy_r[cur_slot] <= 1'b0;
              end
            end else begin
              rem_r[cur_slot]       <= dec_val;
              order_r[wr_r[TW-1:0]] <= cur_slot;
              wr_r                  <= wr_r + ACW'(1);
            end
            idx_r <= idx_r + ACW'(1);
          end else begin
            act_cnt_r <= wr_r;
            state_r   <= S_RESP;
          end
        end
        S_REM: begin
          // shift entries after the removed one down by one place
          if (scan_more) begin
            if (found_r) order_r[idx_r[TW-1:0] - TW'(1)] <= cur_slot;
            if (cur_slot == hnd_r) found_r <= 1'b1;
            idx_r <= idx_r + ACW'(1);
          end else begin
            act_cnt_r     <= act_cnt_r - ACW'(1);
            busy_r[hnd_r] <= 1'b0;
            state_r       <= S_RESP;
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            out_data_r  <= {4'b0, DROPW'(0), ptag_r[pend_head_r],
                            pslot_r[pend_head_r], ST_OK};
            out_last_r  <= (pend_cnt_r == PCW'(1)) || (k_r == PCW'(RESULT_LIMIT - 1));
            pend_head_r <= pend_head_r + PW'(1);
            pend_cnt_r  <= pend_cnt_r - PCW'(1);
            k_r         <= k_r + PCW'(1);
            if ((pend_cnt_r == PCW'(1)) || (k_r == PCW'(RESULT_LIMIT - 1)))
              state_r <= S_IDLE;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_data_r  <= {4'b0, drop_r, TAGW'(0), rs_slot_r, rs_status_r};
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  `POTB_ASSERT_IMPL(a_pend_bound, 1'b1, pend_cnt_r <= PCW'(PENDING_DEPTH))
  `POTB_ASSERT_IMPL(a_busy_count, state_r == S_IDLE, ACW'($countones(busy_r)) == act_cnt_r)
  `POTB_ASSERT_NEXT(a_one_at_time, in_tvalid && in_tready, !in_tready)

endmodule
`default_nettype wire
